// File: design/lbsw_pkg.sv
// ----------------------------------------------------------------------------
// lbsw_pkg - shared types and helpers for the longitude bracket search
// Table geometry, register codes, fixed-point constants and the transaction
// types exchanged between the wrapper and the search core.
// ----------------------------------------------------------------------------
package lbsw_pkg;

  // table geometry
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int BIT_W      = $clog2(IDX_W);

  // fixed field widths
  localparam int CFG_W     = 10;
  localparam int FIELD_IDX = 10;
  localparam int LON_IN_W  = 30;
  localparam int LON_OUT_W = 31;
  localparam int CALC_W    = 32;

  // one full turn in microdegrees
  localparam logic signed [CALC_W-1:0] FULL_TURN = 32'sd360000000;

  // register codes of the configuration port
  typedef enum logic [1:0] {
    REG_LAST_INDEX  = 2'd0,
    REG_GLOBAL_WRAP = 2'd1,
    REG_MATCH_TOL   = 2'd2,
    REG_ROUND_OFS   = 2'd3
  } cfg_reg_e;

  // input item kinds
  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    logic [CFG_W-1:0] last_index;
    logic             global_wrap;
    logic [CFG_W-1:0] match_tolerance;
    logic [CFG_W-1:0] rounding_offset;
  } cfg_t;

  typedef struct packed {
    mode_e                        mode;
    logic [FIELD_IDX-1:0]         entry_index;
    logic signed [LON_IN_W-1:0]   lon_value;
  } item_t;

  typedef struct packed {
    logic [FIELD_IDX-1:0]         west_index;
    logic [FIELD_IDX-1:0]         east_index;
    logic signed [LON_OUT_W-1:0]  west_lon;
    logic signed [LON_OUT_W-1:0]  east_lon;
    logic                         not_found;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

  // search sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD_LO,
    ST_RD_UP,
    ST_CMP,
    ST_FB_SECOND,
    ST_FB_CHK,
    ST_DONE
  } st_e;

  // approximate equality within the tolerance
  function automatic logic same_lon(logic signed [CALC_W-1:0] a,
                                    logic signed [CALC_W-1:0] b,
                                    logic [CFG_W-1:0]         tol);
    logic signed [CALC_W:0] d;
    d = {a[CALC_W-1], a} - {b[CALC_W-1], b};
    if (d[CALC_W]) begin
      d = -d;
    end
    return $unsigned(d) <= (CALC_W+1)'(tol);
  endfunction

endpackage

// File: design/lbsw_ram.sv
// ----------------------------------------------------------------------------
// lbsw_ram - single write, single read synchronous memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lbsw_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/lbsw_core.sv
// ----------------------------------------------------------------------------
// lbsw_core - table memory and bracket search sequencer
// Loads write the longitude table. A query walks the intervals cyclically
// from the hint, one per cycle except at the wrap, then tries the fallbacks.
// ----------------------------------------------------------------------------
module lbsw_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbsw_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  input  lbsw_pkg::item_t     item_i,
  output lbsw_pkg::core_stat_t stat_o,
  output lbsw_pkg::res_t      res_o,
  input  logic                res_ready_i
);
  import lbsw_pkg::*;

  st_e                      state_q, state_d;
  logic [IDX_W-1:0]         i_q, i_d;
  logic [IDX_W-1:0]         cnt_q, cnt_d;
  logic [IDX_W-1:0]         hint_q, hint_d;
  logic [IDX_W:0]           r_q, r_d;
  logic [BIT_W-1:0]         bit_q, bit_d;
  logic signed [CALC_W-1:0] q_q, q_d;
  logic signed [CALC_W-1:0] held_q, held_d;
  res_t                     res_q, res_d;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [LON_IN_W-1:0]      ram_rdata;
  logic signed [CALC_W-1:0] rd_ext;

  logic [IDX_W-1:0]         last;
  logic signed [CALC_W-1:0] v_ext;
  logic signed [CALC_W-1:0] q_start;
  logic [IDX_W:0]           r_shift;
  logic [IDX_W:0]           r_next;
  logic                     accept;

  logic                     hit_in, hit_hi, hit_lo;
  logic                     g_hi, g_lo, s_hit;
  logic signed [CALC_W-1:0] lo_minus, up_plus;
  logic signed [CALC_W-1:0] tl_minus;

  // longitude table
  lbsw_ram #(
    .DEPTH (MAX_POINTS),
    .WIDTH (LON_IN_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(item_i.entry_index)),
    .wdata_i (item_i.lon_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ext = {{(CALC_W-LON_IN_W){ram_rdata[LON_IN_W-1]}}, ram_rdata};
  assign accept = item_valid_i && (state_q == ST_IDLE);
  assign ram_we = accept && (item_i.mode == MODE_LOAD) &&
                  (32'(item_i.entry_index) < 32'(MAX_POINTS));

  // effective last index, saturated to the last table entry
  always_comb begin
    if (32'(cfg_i.last_index) > 32'(MAX_POINTS - 1)) begin
      last = IDX_W'(MAX_POINTS - 1);
    end else begin
      last = IDX_W'(cfg_i.last_index);
    end
  end

  // query preparation: full turn folds to zero, then the rounding offset
  always_comb begin
    v_ext = {{(CALC_W-LON_IN_W){item_i.lon_value[LON_IN_W-1]}}, item_i.lon_value};
    if (same_lon(v_ext, FULL_TURN, cfg_i.match_tolerance)) begin
      q_start = '0;
    end else begin
      q_start = v_ext;
    end
    q_start = q_start + $signed({{(CALC_W-CFG_W){1'b0}}, cfg_i.rounding_offset});
  end

  // one restoring remainder step for hint modulo last
  always_comb begin
    r_shift = {r_q[IDX_W-1:0], hint_q[bit_q]};
    if (r_shift >= {1'b0, last}) begin
      r_next = r_shift - {1'b0, last};
    end else begin
      r_next = r_shift;
    end
  end

  // interval tests: held value is the lower end, read data the upper end
  assign hit_in   = ((q_q > held_q) || same_lon(q_q, held_q, cfg_i.match_tolerance))
                    && (q_q < rd_ext);
  assign hit_hi   = (rd_ext < held_q) && (q_q >= held_q);
  assign hit_lo   = (rd_ext < held_q) && (q_q < rd_ext);
  assign lo_minus = held_q - FULL_TURN;
  assign up_plus  = rd_ext + FULL_TURN;

  // fallback tests: held value is the last entry
  assign g_hi     = ((q_q > held_q) || same_lon(q_q, held_q, cfg_i.match_tolerance))
                    && (q_q < FULL_TURN);
  assign g_lo     = (q_q < rd_ext) || same_lon(q_q, rd_ext, cfg_i.match_tolerance);
  assign s_hit    = same_lon(q_q, held_q, cfg_i.match_tolerance);
  assign tl_minus = held_q - FULL_TURN;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hint_q  <= '0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    cnt_q  <= cnt_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    q_q    <= q_d;
    held_q <= held_d;
    res_q  <= res_d;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    cnt_d     = cnt_q;
    hint_d    = hint_q;
    r_d       = r_q;
    bit_d     = bit_q;
    q_d       = q_q;
    held_d    = held_q;
    res_d     = res_q;
    ram_raddr = i_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.mode == MODE_QUERY)) begin
          q_d   = q_start;
          cnt_d = '0;
          if (last == '0) begin
            res_d           = '0;
            res_d.not_found = 1'b1;
            state_d         = ST_DONE;
          end else if (hint_q >= last) begin
            r_d     = '0;
            bit_d   = BIT_W'(IDX_W - 1);
            state_d = ST_MOD;
          end else begin
            i_d     = hint_q;
            state_d = ST_RD_LO;
          end
        end
      end

      ST_MOD: begin
        r_d   = r_next;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          i_d     = r_next[IDX_W-1:0];
          state_d = ST_RD_LO;
        end
      end

      ST_RD_LO: begin
        ram_raddr = i_q;
        state_d   = ST_RD_UP;
      end

      ST_RD_UP: begin
        ram_raddr = i_q + 1'b1;
        held_d    = rd_ext;
        state_d   = ST_CMP;
      end

      ST_CMP: begin
        res_d.west_index = FIELD_IDX'(i_q);
        res_d.east_index = FIELD_IDX'(i_q + 1'b1);
        res_d.not_found  = 1'b0;
        if (hit_in || hit_hi || hit_lo) begin
          hint_d = i_q;
          if (hit_in) begin
            res_d.west_lon = held_q[LON_OUT_W-1:0];
            res_d.east_lon = rd_ext[LON_OUT_W-1:0];
          end else if (hit_hi) begin
            res_d.west_lon = held_q[LON_OUT_W-1:0];
            res_d.east_lon = up_plus[LON_OUT_W-1:0];
          end else begin
            res_d.west_lon = lo_minus[LON_OUT_W-1:0];
            res_d.east_lon = rd_ext[LON_OUT_W-1:0];
          end
          state_d = ST_DONE;
        end else if (cnt_q + 1'b1 == last) begin
          // walk exhausted: fetch the last entry for the fallbacks
          ram_raddr = last;
          state_d   = ST_FB_SECOND;
        end else if (i_q + 1'b1 == last) begin
          // wrap the walk back to the first interval
          cnt_d     = cnt_q + 1'b1;
          i_d       = '0;
          ram_raddr = '0;
          state_d   = ST_RD_UP;
        end else begin
          // next interval reuses this upper end as its lower end
          cnt_d     = cnt_q + 1'b1;
          i_d       = i_q + 1'b1;
          ram_raddr = i_q + IDX_W'(2);
          held_d    = rd_ext;
        end
      end

      ST_FB_SECOND: begin
        held_d = rd_ext;
        if (cfg_i.global_wrap) begin
          ram_raddr = '0;
        end else begin
          ram_raddr = last - 1'b1;
        end
        state_d = ST_FB_CHK;
      end

      ST_FB_CHK: begin
        res_d   = '0;
        state_d = ST_DONE;
        if (cfg_i.global_wrap) begin
          if (g_hi) begin
            res_d.west_index = FIELD_IDX'(last);
            res_d.west_lon   = held_q[LON_OUT_W-1:0];
            res_d.east_lon   = FULL_TURN[LON_OUT_W-1:0];
          end else if (g_lo) begin
            res_d.west_index = FIELD_IDX'(last);
            res_d.west_lon   = tl_minus[LON_OUT_W-1:0];
            res_d.east_lon   = rd_ext[LON_OUT_W-1:0];
          end else begin
            res_d.not_found  = 1'b1;
          end
        end else if (s_hit) begin
          res_d.west_index = FIELD_IDX'(last - 1'b1);
          res_d.east_index = FIELD_IDX'(last);
          res_d.west_lon   = rd_ext[LON_OUT_W-1:0];
          res_d.east_lon   = held_q[LON_OUT_W-1:0];
        end else begin
          res_d.not_found  = 1'b1;
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign stat_o.idle      = (state_q == ST_IDLE);
  assign stat_o.res_valid = (state_q == ST_DONE);
  assign res_o            = res_q;

endmodule

// File: design/longitude_bracket_search_wrap.sv
// ----------------------------------------------------------------------------
// longitude_bracket_search_wrap - longitude bracket search with wraparound
// Stream wrapper: configuration registers, search core and output register.
// ----------------------------------------------------------------------------
// A load transaction writes one table entry. A query walks the table
// intervals from the search hint at one interval per cycle, limited by the
// single read port of the table memory, except when the walk passes the last
// interval and restarts at the first. When last_index was lowered to or below
// the hint, the hint is first reduced modulo last_index one bit per cycle. A
// query that finds no interval ends with the fallback checks; with a zero
// last_index it answers not found without walking the table. The table needs
// no clearing after reset; an entry read before it was loaded gives arbitrary
// neighbour values.
// Configuration writes are taken in every cycle and must only be issued while
// the block is idle.
module longitude_bracket_search_wrap (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // entry_index[9:0], lon_value[39:10]
  input  logic        s_axis_tuser_i,   // mode
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // west_index[9:0], east_index[19:10],
                                        // west_lon[50:20], east_lon[81:51]
  output logic        m_axis_tuser_o    // not_found
);
  import lbsw_pkg::*;

  cfg_t       cfg_q, cfg_d;
  item_t      item;
  res_t       core_res;
  core_stat_t core_stat;
  logic       core_res_ready;
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q, out_res_d;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_LAST_INDEX:  cfg_d.last_index      = cfg_wdata_i;
        REG_GLOBAL_WRAP: cfg_d.global_wrap     = cfg_wdata_i[0];
        REG_MATCH_TOL:   cfg_d.match_tolerance = cfg_wdata_i;
        REG_ROUND_OFS:   cfg_d.rounding_offset = cfg_wdata_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.last_index      <= CFG_W'(1);
      cfg_q.global_wrap     <= 1'b0;
      cfg_q.match_tolerance <= CFG_W'(1);
      cfg_q.rounding_offset <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input unpacking
  assign item.mode        = mode_e'(s_axis_tuser_i);
  assign item.entry_index = s_axis_tdata_i[9:0];
  assign item.lon_value   = s_axis_tdata_i[39:10];
  assign s_axis_tready_o  = core_stat.idle;

  lbsw_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid_i),
    .item_i       (item),
    .stat_o       (core_stat),
    .res_o        (core_res),
    .res_ready_i  (core_res_ready)
  );

  // output register
  assign core_res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (core_res_ready) begin
      out_valid_d = core_stat.res_valid;
      if (core_stat.res_valid) begin
        out_res_d = core_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  // result packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_res_q.east_lon, out_res_q.west_lon,
                            out_res_q.east_index, out_res_q.west_index};
  assign m_axis_tuser_o  = out_res_q.not_found;

  // a not-found result carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("not-found result with non-zero fields");

  // the core never offers a result while it takes input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !core_stat.res_valid)
    else $error("core result pending while idle");

  // a load transaction causes no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i |=>
      s_axis_tready_o && !core_stat.res_valid)
    else $error("load transaction left the core busy");

  // a query transaction occupies the core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> !s_axis_tready_o)
    else $error("query transaction did not start a search");

endmodule
